[design/trc_pkg.sv]
// package for the timed relay controller: widths, codes, item types and helpers
package trc_pkg;

  // bank size and default relay count
  localparam int BANK_SIZE         = 8;
  localparam int RELAY_COUNT_DFLT  = 8;

  // operation codes
  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_SET       = 2'd1;
  localparam logic [1:0] OP_TIMED_SET = 2'd2;

  // action codes, shared by the set action and the after-action
  localparam logic [1:0] ACT_OFF     = 2'd0;
  localparam logic [1:0] ACT_ON      = 2'd1;
  localparam logic [1:0] ACT_INVERT  = 2'd2;
  localparam logic [1:0] ACT_RESTORE = 2'd3;

  // input item
  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  relay_index;
    logic [1:0]  action;
    logic [31:0] duration;
    logic [1:0]  after_action;
  } trc_in_t;

  // result item
  typedef struct packed {
    logic                 accepted;
    logic [BANK_SIZE-1:0] relay_states;
    logic [BANK_SIZE-1:0] expired_mask;
  } trc_out_t;

  // command decoded for one relay lane
  typedef struct packed {
    logic        en;
    logic        tick;
    logic        set;
    logic        arm;
    logic [1:0]  action;
    logic [1:0]  after_action;
    logic [31:0] duration;
  } trc_lane_cmd_t;

  // new relay state after an action; any code other than off and invert acts as on
  function automatic logic drive_fn(input logic cur, input logic [1:0] act);
    logic res;
    case (act)
      ACT_OFF:    res = 1'b0;
      ACT_INVERT: res = ~cur;
      default:    res = 1'b1;
    endcase
    return res;
  endfunction

endpackage

[design/timed_relay_controller_top.sv]
// top level of the timed relay controller: item register, relay lanes, result register
//
//   channel | ports                          | payload
//   input   | in_valid, in_stall, in_data    | trc_in_t
//   result  | out_valid, out_stall, out_data | trc_out_t
//
// one item per cycle sustained while the result side does not stall; a taken item passes
// the item register, then the result register, and every lane updates in the same cycle
// reset clears all relays, timers and both valid flags
// a stalled result holds the result register, which then stalls the item register
// and in turn the input channel
module timed_relay_controller_top #(
  parameter int RELAY_COUNT = trc_pkg::RELAY_COUNT_DFLT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  trc_pkg::trc_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output trc_pkg::trc_out_t out_data
);
  import trc_pkg::*;

  localparam logic [4:0] CNT = 5'(RELAY_COUNT);
  localparam logic [BANK_SIZE-1:0] STATE_MASK = BANK_SIZE'((9'd1 << RELAY_COUNT) - 9'd1);

  logic     hold_valid_r;
  trc_in_t  hold_r;
  logic     out_valid_r;
  trc_out_t out_r;
  trc_out_t result;
  logic     advance;
  logic     idx_ok;
  logic     is_tick, is_set, is_timed;
  logic [BANK_SIZE-1:0] states_nxt;
  logic [BANK_SIZE-1:0] expired_v;

  // pipeline moves when the result register is free or being taken
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = hold_valid_r && !advance;

  // item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (!in_stall) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      hold_r <= in_data;
    end
  end

  // decode of the held item
  assign is_tick  = (hold_r.operation == OP_TICK);
  assign is_set   = (hold_r.operation == OP_SET);
  assign is_timed = (hold_r.operation == OP_TIMED_SET);
  assign idx_ok   = ({1'b0, hold_r.relay_index} < CNT);

  // relay lanes
  genvar g;
  generate
    for (g = 0; g < BANK_SIZE; g++) begin : g_lane
      if (g < RELAY_COUNT) begin : g_used
        trc_lane_cmd_t cmd;
        always_comb begin
          cmd.en           = hold_valid_r && advance;
          cmd.tick         = is_tick;
          cmd.set          = (is_set || is_timed) && idx_ok &&
                             (hold_r.relay_index == 4'(g));
          cmd.arm          = is_timed && (hold_r.duration != 32'd0);
          cmd.action       = hold_r.action;
          cmd.after_action = hold_r.after_action;
          cmd.duration     = hold_r.duration;
        end
        trc_timer_lane u_lane (
          .clk          (clk),
          .rst_n        (rst_n),
          .cmd          (cmd),
          .relay_on_nxt (states_nxt[g]),
          .expired      (expired_v[g])
        );
      end else begin : g_unused
        assign states_nxt[g] = 1'b0;
        assign expired_v[g]  = 1'b0;
      end
    end
  endgenerate

  // result of the held item
  always_comb begin
    result.accepted     = is_tick || ((is_set || is_timed) && idx_ok);
    result.relay_states = states_nxt;
    result.expired_mask = expired_v;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= hold_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_expired_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.expired_mask != '0)) |-> out_data.accepted)
    else $error("timer expiry reported on a rejected item");

  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.relay_states & ~STATE_MASK) == '0))
    else $error("relay state reported beyond relay count");

endmodule

[design/trc_timer_lane.sv]
// one relay lane: relay state, timer and after-action
module trc_timer_lane (
  input  logic                   clk,
  input  logic                   rst_n,
  input  trc_pkg::trc_lane_cmd_t cmd,
  output logic                   relay_on_nxt,
  output logic                   expired
);
  import trc_pkg::*;

  logic        relay_on_r;
  logic        armed_r,     armed_nxt;
  logic [31:0] remain_r,    remain_nxt;
  logic [1:0]  revert_r,    revert_nxt;
  logic        on_mid;

  // tick handling, then command handling
  always_comb begin
    on_mid       = relay_on_r;
    armed_nxt    = armed_r;
    remain_nxt   = remain_r;
    revert_nxt   = revert_r;
    expired      = 1'b0;
    relay_on_nxt = relay_on_r;
    if (cmd.en) begin
      if (cmd.tick && armed_r) begin
        if (remain_r == 32'd0) begin
          armed_nxt = 1'b0;
          on_mid    = drive_fn(relay_on_r, revert_r);
          expired   = 1'b1;
        end else begin
          remain_nxt = remain_r - 32'd1;
        end
      end
      relay_on_nxt = on_mid;
      if (cmd.set) begin
        relay_on_nxt = drive_fn(relay_on_r, cmd.action);
        if (cmd.arm) begin
          armed_nxt  = 1'b1;
          remain_nxt = cmd.duration;
          revert_nxt = (cmd.after_action == ACT_RESTORE) ? {1'b0, relay_on_r}
                                                          : cmd.after_action;
        end
      end
    end
  end

  // lane state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_on_r <= 1'b0;
      armed_r    <= 1'b0;
      remain_r   <= '0;
      revert_r   <= ACT_OFF;
    end else begin
      relay_on_r <= relay_on_nxt;
      armed_r    <= armed_nxt;
      remain_r   <= remain_nxt;
      revert_r   <= revert_nxt;
    end
  end

endmodule

[tb/tb.sv]
// self-checking testbench for the timed relay controller top level
module tb;
  import trc_pkg::*;

  localparam int RELAY_N     = RELAY_COUNT_DFLT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_RUN  = 450;

  // an operation code the block does not define, and action code 3 (restore) as a set action
  localparam logic [1:0] OP_UNDEF  = 2'd3;
  localparam logic [1:0] ACT_UNDEF = 2'd3;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  trc_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  trc_out_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;

  // relay bank predictor and queue of predicted results
  class relay_scoreboard;
    logic [RELAY_N-1:0] relay_level;
    logic [RELAY_N-1:0] timer_run;
    logic [31:0]        ticks_left[RELAY_N];
    logic [1:0]         expiry_act[RELAY_N];
    trc_out_t           due[$];
    int errors = 0;
    int commands = 0;
    int refused = 0;
    int results = 0;
    int expiries = 0;

    function new();
      relay_level = '0;
      timer_run   = '0;
      foreach (ticks_left[i]) begin
        ticks_left[i] = '0;
        expiry_act[i] = ACT_OFF;
      end
    endfunction

    // level of one relay after an action; any code other than off and invert switches it on
    function logic next_level(logic cur, logic [1:0] act);
      if (act == ACT_OFF) return 1'b0;
      if (act == ACT_INVERT) return ~cur;
      return 1'b1;
    endfunction

    // note an accepted item and predict its result
    function void note_command(trc_in_t it);
      trc_out_t r;
      logic     prior;
      int       idx;
      r   = '0;
      idx = it.relay_index;
      commands++;
      if (it.operation == OP_TICK) begin
        r.accepted = 1'b1;
        for (int i = 0; i < RELAY_N; i++) begin
          if (timer_run[i]) begin
            if (ticks_left[i] == 0) begin
              timer_run[i]      = 1'b0;
              relay_level[i]    = next_level(relay_level[i], expiry_act[i]);
              r.expired_mask[i] = 1'b1;
            end else begin
              ticks_left[i] = ticks_left[i] - 1;
            end
          end
        end
      end else if ((it.operation == OP_SET || it.operation == OP_TIMED_SET)
                   && idx < RELAY_N) begin
        prior            = relay_level[idx];
        r.accepted       = 1'b1;
        relay_level[idx] = next_level(prior, it.action);
        // nonzero duration (re)arms the timer; restore resolves to the prior level
        if (it.operation == OP_TIMED_SET && it.duration != 0) begin
          timer_run[idx]  = 1'b1;
          ticks_left[idx] = it.duration;
          if (it.after_action == ACT_RESTORE)
            expiry_act[idx] = prior ? ACT_ON : ACT_OFF;
          else
            expiry_act[idx] = it.after_action;
        end
      end else begin
        refused++;
      end
      for (int i = 0; i < RELAY_N; i++) r.relay_states[i] = relay_level[i];
      due.push_back(r);
    endfunction

    // compare a result with the oldest prediction
    function void check_result(trc_out_t got);
      trc_out_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: accepted %0b states %h expired %h",
                 $time, got.accepted, got.relay_states, got.expired_mask);
        return;
      end
      want = due.pop_front();
      results++;
      expiries += $countones(want.expired_mask);
      if (got.accepted !== want.accepted) begin
        errors++;
        $display("%0t: accepted expected %0b actual %0b",
                 $time, want.accepted, got.accepted);
      end
      if (got.relay_states !== want.relay_states) begin
        errors++;
        $display("%0t: relay_states expected %h actual %h",
                 $time, want.relay_states, got.relay_states);
      end
      if (got.expired_mask !== want.expired_mask) begin
        errors++;
        $display("%0t: expired_mask expected %h actual %h",
                 $time, want.expired_mask, got.expired_mask);
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  relay_scoreboard sb = new();

  timed_relay_controller_top #(.RELAY_COUNT(RELAY_N)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run limit reached with %0d results outstanding", $time, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: check each result taken, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) sb.check_result(out_data);
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic trc_in_t relay_cmd(logic [1:0] op, logic [3:0] idx, logic [1:0] act,
                                        logic [31:0] dur, logic [1:0] aft);
    trc_in_t it;
    it.operation    = op;
    it.relay_index  = idx;
    it.action       = act;
    it.duration     = dur;
    it.after_action = aft;
    return it;
  endfunction

  // mostly ticks and timed sets on real relays with short timers
  function automatic trc_in_t random_cmd();
    trc_in_t it;
    int      pick;
    pick = $urandom_range(99);
    if (pick < 45)      it.operation = OP_TICK;
    else if (pick < 65) it.operation = OP_SET;
    else if (pick < 95) it.operation = OP_TIMED_SET;
    else                it.operation = OP_UNDEF;
    if ($urandom_range(99) < 85) it.relay_index = 4'($urandom_range(RELAY_N - 1));
    else                         it.relay_index = 4'($urandom_range(15, RELAY_N));
    it.action       = 2'($urandom_range(3));
    it.after_action = 2'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 15)      it.duration = '0;
    else if (pick < 92) it.duration = $urandom_range(1, 8);
    else                it.duration = $urandom;
    return it;
  endfunction

  // offer one item, with an optional gap first, and wait until it is taken
  task automatic send_item(input trc_in_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_command(it);
  endtask

  initial begin
    trc_in_t plan[$];
    int      send_pct[3];
    int      recv_pct[3];
    send_pct = '{15, 72, 0};
    recv_pct = '{72, 15, 0};
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    rst_n     <= 1'b0;
    send_idle_pct = send_pct[0];
    recv_idle_pct = recv_pct[0];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, refused commands and the timer corner cases
    plan.push_back(relay_cmd(OP_TICK, 4'd0, ACT_OFF, 32'd0, ACT_OFF));
    plan.push_back(relay_cmd(OP_SET, 4'd0, ACT_ON, 32'd0, ACT_OFF));
    plan.push_back(relay_cmd(OP_SET, 4'd7, ACT_INVERT, 32'hFFFF_FFFF, ACT_RESTORE));
    plan.push_back(relay_cmd(OP_SET, 4'd8, ACT_ON, 32'd0, ACT_OFF));
    plan.push_back(relay_cmd(OP_SET, 4'd15, ACT_OFF, 32'd0, ACT_OFF));
    plan.push_back(relay_cmd(OP_UNDEF, 4'd0, ACT_OFF, 32'd3, ACT_ON));
    plan.push_back(relay_cmd(OP_SET, 4'd1, ACT_UNDEF, 32'd0, ACT_OFF));
    plan.push_back(relay_cmd(OP_TIMED_SET, 4'd2, ACT_ON, 32'd2, ACT_OFF));
    plan.push_back(relay_cmd(OP_TIMED_SET, 4'd0, ACT_OFF, 32'd0, ACT_ON));
    plan.push_back(relay_cmd(OP_TIMED_SET, 4'd3, ACT_INVERT, 32'd1, ACT_RESTORE));
    plan.push_back(relay_cmd(OP_TICK, 4'd15, ACT_UNDEF, 32'hFFFF_FFFF, ACT_RESTORE));
    plan.push_back(relay_cmd(OP_SET, 4'd2, ACT_INVERT, 32'd0, ACT_OFF));
    plan.push_back(relay_cmd(OP_TICK, 4'd0, ACT_OFF, 32'd0, ACT_OFF));
    plan.push_back(relay_cmd(OP_TICK, 4'd0, ACT_OFF, 32'd0, ACT_OFF));
    plan.push_back(relay_cmd(OP_TIMED_SET, 4'd4, ACT_ON, 32'd5, ACT_INVERT));
    plan.push_back(relay_cmd(OP_TIMED_SET, 4'd4, ACT_OFF, 32'd1, ACT_ON));
    plan.push_back(relay_cmd(OP_TICK, 4'd0, ACT_OFF, 32'd0, ACT_OFF));
    plan.push_back(relay_cmd(OP_TICK, 4'd0, ACT_OFF, 32'd0, ACT_OFF));
    plan.push_back(relay_cmd(OP_TIMED_SET, 4'd5, ACT_ON, 32'hFFFF_FFFF, ACT_RESTORE));
    plan.push_back(relay_cmd(OP_TIMED_SET, 4'd6, ACT_INVERT, 32'h8000_0000, ACT_INVERT));
    plan.push_back(relay_cmd(OP_TIMED_SET, 4'd15, ACT_ON, 32'd1, ACT_RESTORE));
    plan.push_back(relay_cmd(OP_TIMED_SET, 4'd1, ACT_OFF, 32'd1, ACT_RESTORE));
    plan.push_back(relay_cmd(OP_TICK, 4'd0, ACT_OFF, 32'd0, ACT_OFF));
    plan.push_back(relay_cmd(OP_TICK, 4'd0, ACT_OFF, 32'd0, ACT_OFF));
    foreach (plan[i]) send_item(plan[i]);

    // random phases with shifting idle patterns on both sides
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      for (int k = 0; k < RANDOM_RUN; k++) send_item(random_cmd());
    end
    in_valid <= 1'b0;

    // drain, then let the pipeline settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d items, %0d of them refused, %0d results checked",
             sb.commands, sb.refused, sb.results);
    $display("timer expiries seen: %0d, mismatches: %0d", sb.expiries, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[timed_relay_controller_top.f]
design/trc_pkg.sv
design/trc_timer_lane.sv
design/timed_relay_controller_top.sv
tb/tb.sv
